// ===== hdl/staggered_goertzel_phasor_defines.svh =====
// Assertion macros used by the staggered Goertzel phasor top level.
`ifndef STAGGERED_GOERTZEL_PHASOR_DEFINES_SVH
`define STAGGERED_GOERTZEL_PHASOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SGP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SGP_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SGP_ASSERT(lbl, prop, msg)
`define SGP_ASSERT_NORST(lbl, prop, msg)
`endif
`endif

// ===== hdl/sgp_pkg.sv =====
// Constants, types and tables of the staggered Goertzel phasor block.
package sgp_pkg;
  localparam int NUM_SUMS      = 4;
  localparam int SAMPLE_BITS   = 16;
  localparam int MAX_POINTS    = 256;
  localparam int POINTS_RESET  = 40;
  localparam int CORDIC_ITERS  = 30;
  localparam int CORDIC_GAIN24 = 10188012;

  localparam int IDX_W      = $clog2(NUM_SUMS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ITER_W     = $clog2(CORDIC_ITERS);
  localparam int DELAY_W    = 48;
  localparam int OPC_W      = 25;
  localparam int PROD_W     = 2 * OPC_W;
  localparam int MACC_W     = 58;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_POINTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_WY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TWO_OVER_N = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQ = 3'd4;

  typedef struct packed {
    logic lo_en;
    logic hi_en;
  } mul_ctrl_t;

  function automatic logic [31:0] atan_angle(input logic [ITER_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction
endpackage

// ===== hdl/sgp_if.sv =====
// Sample and result channel interfaces.
interface sgp_sample_if import sgp_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface sgp_result_if import sgp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        sum_index;
  logic signed [16:0]      real_part;
  logic signed [16:0]      imag_part;
  logic [16:0]             magnitude;
  logic signed [15:0]      phase_angle;
  logic signed [16:0]      phase_step;
  logic [16:0]             frequency_mhz;
  modport source (output valid, output sum_index, output real_part, output imag_part,
                  output magnitude, output phase_angle, output phase_step,
                  output frequency_mhz, input ready);
  modport sink (input valid, input sum_index, input real_part, input imag_part,
                input magnitude, input phase_angle, input phase_step,
                input frequency_mhz, output ready);
endinterface

// ===== hdl/sgp_mulq.sv =====
// Shared two-pass multiplier: floor(v*c/2^16) from split partial products.
module sgp_mulq import sgp_pkg::*; (
  input  logic                      clk_i,
  input  mul_ctrl_t                 ctrl_i,
  input  logic signed [DELAY_W-1:0] v_i,
  input  logic signed [OPC_W-1:0]   c_i,
  output logic signed [MACC_W-1:0]  m_o
);
  logic signed [OPC_W-1:0]  piece;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] lo_q;
  logic signed [PROD_W-1:0] hi_q;

  assign piece = ctrl_i.hi_en ? $signed({v_i[DELAY_W-1], v_i[DELAY_W-1:24]})
                              : $signed({1'b0, v_i[23:0]});
  assign prod  = piece * c_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.lo_en) begin
      lo_q <= prod;
    end
    if (ctrl_i.hi_en) begin
      hi_q <= prod;
    end
  end

  assign m_o = (MACC_W'(hi_q) <<< 8) + MACC_W'(lo_q >>> 16);
endmodule

// ===== hdl/staggered_goertzel_phasor.sv =====
// Top level of the staggered Goertzel phasor estimator.
// An item that closes no window is accepted, then passes a low pass, a high pass and a sum
// step per sum; one that closes a window adds further shared multiplier passes and the 30
// CORDIC iterations (skipped for a zero vector); the block takes one item at a time.
// The result waits in an output register; a new result stalls only if it is untaken.
// Reset (async, low) loads default registers, clears sums and restaggers the counters.
`include "staggered_goertzel_phasor_defines.svh"
module staggered_goertzel_phasor import sgp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sgp_sample_if.sink            sample_i,
  sgp_result_if.source          result_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_M_LO  = 3'd1;
  localparam logic [2:0] S_M_HI  = 3'd2;
  localparam logic [2:0] S_M_SUM = 3'd3;
  localparam logic [2:0] S_CPRE  = 3'd4;
  localparam logic [2:0] S_CITER = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [2:0] J_ACC = 3'd0;
  localparam logic [2:0] J_RE  = 3'd1;
  localparam logic [2:0] J_IM  = 3'd2;
  localparam logic [2:0] J_RS  = 3'd3;
  localparam logic [2:0] J_IS  = 3'd4;
  localparam logic [2:0] J_MAG = 3'd5;

  localparam int ANG_SHIFT = 32 - IDX_W;
  localparam logic signed [MACC_W-1:0] CLAMP33 = 58'sd8589934591;

  logic [2:0] state_q, state_d;
  logic [2:0] job_q;

  logic [8:0]         points_q;
  logic signed [17:0] coef_a_q;
  logic [16:0]        coef_wy_q;
  logic [15:0]        two_over_n_q;
  logic [16:0]        base_q;

  logic signed [DELAY_W-1:0] d1_q [NUM_SUMS];
  logic signed [DELAY_W-1:0] d2_q [NUM_SUMS];
  logic [CNT_W-1:0]          cnt_q [NUM_SUMS];
  logic signed [15:0]        last_q;

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic [IDX_W-1:0]              idx_q, sel_q;
  logic                          found_q;
  logic signed [DELAY_W-1:0]     re_q, im_q;
  logic signed [33:0]            re16_q, im16_q;
  logic signed [37:0]            cx_q, cy_q;
  logic [31:0]                   ca_q;
  logic [ITER_W-1:0]             it_q;
  logic [16:0]                   mag_q;
  logic                          out_valid_q;

  mul_ctrl_t                 mul_ctrl;
  logic signed [DELAY_W-1:0] mul_v;
  logic signed [OPC_W-1:0]   mul_c;
  logic signed [MACC_W-1:0]  mul_m;

  logic [CNT_W-1:0]          n_eff;
  logic [CNT_W-1:0]          cnt_inc;
  logic                      hit;
  logic signed [MACC_W-1:0]  acc_s;
  logic signed [MACC_W-1:0]  re_s;
  logic signed [MACC_W-1:0]  mag_pre, mag_sum;
  logic [16:0]               mag_val;
  logic signed [37:0]        sx, sy, nx, ny;
  logic [31:0]               na;
  logic [31:0]               ang32, ang_r;
  logic signed [15:0]        ang16;
  logic signed [16:0]        dstep;
  logic signed [27:0]        dk, qn;
  logic signed [19:0]        f_full;
  logic [16:0]               f_val;
  logic signed [35:0]        rr, ri;
  logic                      out_fire;
  logic                      in_fire;

  function automatic logic signed [DELAY_W-1:0] sat48(input logic signed [MACC_W-1:0] v);
    logic signed [DELAY_W-1:0] r;
    if (v[MACC_W-1:DELAY_W-1] == {(MACC_W-DELAY_W+1){v[DELAY_W-1]}}) begin
      r = v[DELAY_W-1:0];
    end else if (v[MACC_W-1]) begin
      r = {1'b1, {(DELAY_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DELAY_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [33:0] sat33(input logic signed [MACC_W-1:0] v);
    logic signed [33:0] r;
    if (v > CLAMP33) begin
      r = 34'(CLAMP33);
    end else if (v < -CLAMP33) begin
      r = 34'(-CLAMP33);
    end else begin
      r = v[33:0];
    end
    return r;
  endfunction

  function automatic logic signed [16:0] sat17(input logic signed [35:0] v);
    logic signed [16:0] r;
    if (v > 36'sd65535) begin
      r = 17'sd65535;
    end else if (v < -36'sd65536) begin
      r = -17'sd65536;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

  sgp_mulq u_mulq (
    .clk_i  (clk_i),
    .ctrl_i (mul_ctrl),
    .v_i    (mul_v),
    .c_i    (mul_c),
    .m_o    (mul_m)
  );

  assign mul_ctrl.lo_en = (state_q == S_M_LO);
  assign mul_ctrl.hi_en = (state_q == S_M_HI);

  always_comb begin
    case (job_q)
      J_RS:    mul_v = re_q;
      J_IS:    mul_v = im_q;
      J_MAG:   mul_v = cx_q[37] ? '0 : DELAY_W'(cx_q);
      default: mul_v = d1_q[idx_q];
    endcase
    case (job_q)
      J_IM:       mul_c = $signed({8'b0, coef_wy_q});
      J_RS, J_IS: mul_c = $signed({9'b0, two_over_n_q});
      J_MAG:      mul_c = 25'sd10188012;
      default:    mul_c = OPC_W'(coef_a_q);
    endcase
  end

  assign n_eff   = (points_q < 9'd4) ? CNT_W'(4) :
                   ((points_q > 9'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(points_q));
  assign cnt_inc = (cnt_q[idx_q] < CNT_W'(MAX_POINTS)) ? cnt_q[idx_q] + 1'b1 : cnt_q[idx_q];
  assign hit     = (cnt_inc >= n_eff);
  assign acc_s   = mul_m - MACC_W'(d2_q[idx_q]) + (MACC_W'(x_q) <<< 16);
  assign re_s    = (mul_m >>> 1) - MACC_W'(d2_q[idx_q]);
  assign mag_pre = (mul_m + 58'sd128) >>> 8;
  assign mag_sum = (mag_pre + 58'sd32768) >>> 16;
  assign mag_val = (|mag_sum[MACC_W-1:17]) ? 17'h1FFFF : mag_sum[16:0];

  assign sx = cx_q >>> it_q;
  assign sy = cy_q >>> it_q;
  always_comb begin
    if (cy_q > 38'sd0) begin
      nx = cx_q + sy;
      ny = cy_q - sx;
      na = ca_q + atan_angle(it_q);
    end else begin
      nx = cx_q - sy;
      ny = cy_q + sx;
      na = ca_q - atan_angle(it_q);
    end
  end

  assign ang32  = ca_q + (32'(idx_q) << ANG_SHIFT);
  assign ang_r  = ang32 + 32'h0000_8000;
  assign ang16  = $signed(ang_r[31:16]);
  assign dstep  = 17'(ang16) - 17'(last_q);
  assign dk     = 28'(dstep) * 28'sd1000;
  assign qn     = (dk + 28'sd131072) >>> 18;
  assign f_full = $signed({3'b000, base_q}) + 20'(qn);
  assign f_val  = f_full[19] ? 17'd0 : ((|f_full[18:17]) ? 17'h1FFFF : f_full[16:0]);
  assign rr     = (36'(re16_q) + 36'sd32768) >>> 16;
  assign ri     = (36'(im16_q) + 36'sd32768) >>> 16;

  assign in_fire  = sample_i.valid && sample_i.ready;
  assign out_fire = (state_q == S_OUT) && (!out_valid_q || result_o.ready);
  assign sample_i.ready = (state_q == S_IDLE);
  assign result_o.valid = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_M_LO;
      S_M_LO:  state_d = S_M_HI;
      S_M_HI:  state_d = S_M_SUM;
      S_M_SUM: begin
        unique case (job_q)
          J_ACC: begin
            if (idx_q != IDX_W'(NUM_SUMS - 1)) begin
              state_d = S_M_LO;
            end else if (found_q || hit) begin
              state_d = S_M_LO;
            end else begin
              state_d = S_IDLE;
            end
          end
          J_IS:    state_d = S_CPRE;
          J_MAG:   state_d = S_OUT;
          default: state_d = S_M_LO;
        endcase
      end
      S_CPRE:  state_d = (re16_q == '0 && im16_q == '0) ? S_M_LO : S_CITER;
      S_CITER: if (it_q == ITER_W'(CORDIC_ITERS - 1)) state_d = S_M_LO;
      S_OUT:   if (out_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      job_q        <= J_ACC;
      points_q     <= 9'(POINTS_RESET);
      coef_a_q     <= 18'sd129460;
      coef_wy_q    <= 17'd10252;
      two_over_n_q <= 16'd3277;
      base_q       <= 17'd49000;
      for (int k = 0; k < NUM_SUMS; k++) begin
        d1_q[k]  <= '0;
        d2_q[k]  <= '0;
        cnt_q[k] <= CNT_W'(k * POINTS_RESET / NUM_SUMS);
      end
      last_q      <= '0;
      idx_q       <= '0;
      sel_q       <= '0;
      found_q     <= 1'b0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_POINTS:     points_q     <= cfg_data_i[8:0];
          REG_COEF_A:     coef_a_q     <= $signed(cfg_data_i[17:0]);
          REG_COEF_WY:    coef_wy_q    <= cfg_data_i[16:0];
          REG_TWO_OVER_N: two_over_n_q <= cfg_data_i[15:0];
          REG_BASE_FREQ:  base_q       <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (out_valid_q && result_o.ready && !out_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            x_q     <= sample_i.sample;
            idx_q   <= '0;
            found_q <= 1'b0;
            job_q   <= J_ACC;
          end
        end
        S_M_SUM: begin
          unique case (job_q)
            J_ACC: begin
              d2_q[idx_q]  <= d1_q[idx_q];
              d1_q[idx_q]  <= sat48(acc_s);
              cnt_q[idx_q] <= cnt_inc;
              if (!found_q && hit) begin
                found_q <= 1'b1;
                sel_q   <= idx_q;
              end
              if (idx_q != IDX_W'(NUM_SUMS - 1)) begin
                idx_q <= idx_q + 1'b1;
              end else begin
                idx_q <= found_q ? sel_q : idx_q;
                job_q <= J_RE;
              end
            end
            J_RE: begin
              re_q  <= sat48(re_s);
              job_q <= J_IM;
            end
            J_IM: begin
              im_q  <= sat48(mul_m);
              job_q <= J_RS;
            end
            J_RS: begin
              re16_q <= sat33(mul_m);
              job_q  <= J_IS;
            end
            J_IS: begin
              im16_q <= sat33(mul_m);
            end
            J_MAG: begin
              mag_q <= mag_val;
            end
            default: ;
          endcase
        end
        S_CPRE: begin
          it_q <= '0;
          if (re16_q == '0 && im16_q == '0) begin
            cx_q  <= '0;
            cy_q  <= '0;
            ca_q  <= '0;
            job_q <= J_MAG;
          end else if (re16_q < 34'sd0) begin
            cx_q <= -38'(re16_q);
            cy_q <= -38'(im16_q);
            ca_q <= 32'h8000_0000;
          end else begin
            cx_q <= 38'(re16_q);
            cy_q <= 38'(im16_q);
            ca_q <= '0;
          end
        end
        S_CITER: begin
          cx_q <= nx;
          cy_q <= ny;
          ca_q <= na;
          it_q <= it_q + 1'b1;
          if (it_q == ITER_W'(CORDIC_ITERS - 1)) begin
            job_q <= J_MAG;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            out_valid_q         <= 1'b1;
            result_o.sum_index  <= idx_q;
            result_o.real_part  <= sat17(rr);
            result_o.imag_part  <= sat17(ri);
            result_o.magnitude  <= mag_q;
            result_o.phase_angle <= ang16;
            result_o.phase_step <= dstep;
            result_o.frequency_mhz <= f_val;
            last_q       <= ang16;
            d1_q[idx_q]  <= '0;
            d2_q[idx_q]  <= '0;
            cnt_q[idx_q] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `SGP_ASSERT(a_accept_starts_acc, in_fire |=> (state_q == S_M_LO && job_q == J_ACC), "accepted item did not start accumulation")
  `SGP_ASSERT(a_iter_bound, (state_q == S_CITER) |-> (it_q < ITER_W'(CORDIC_ITERS)), "CORDIC counter overran")
  `SGP_ASSERT(a_result_from_out, $rose(out_valid_q) |-> $past(state_q == S_OUT), "result raised outside output step")
  `SGP_ASSERT(a_mag_then_out, (state_q == S_M_SUM && job_q == J_MAG) |=> (state_q == S_OUT), "magnitude pass not followed by output")
  `SGP_ASSERT_NORST(a_no_valid_in_reset, !rst_ni |-> !result_o.valid, "result valid during reset")
endmodule

// ===== tb/sv/tb_staggered_goertzel_phasor.sv =====
// Self-checking testbench of the staggered Goertzel phasor estimator.
module tb_staggered_goertzel_phasor;
  import sgp_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]   sum_index;
    logic signed [16:0] real_part;
    logic signed [16:0] imag_part;
    logic [16:0]        magnitude;
    logic signed [15:0] phase_angle;
    logic signed [16:0] phase_step;
    logic [16:0]        frequency_mhz;
  } phasor_t;

  typedef struct {
    logic signed [15:0] sample;
    bit                 typed;
    phasor_t            phasor;
  } sample_row_t;

  localparam longint MAX48 = 64'sd140737488355327;
  localparam longint CLAMP33 = 64'sd8589934591;
  localparam int DRAIN_CYCLES = 100;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  sgp_sample_if smp ();
  sgp_result_if res ();

  staggered_goertzel_phasor u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (smp.sink),
    .result_o   (res.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int unsigned cfg_points;
  longint      cfg_coef_a;
  longint      cfg_coef_wy;
  longint      cfg_two_over_n;
  longint      cfg_base_freq;
  longint      delay_one_q[NUM_SUMS];
  longint      delay_two_q[NUM_SUMS];
  int unsigned window_count[NUM_SUMS];
  int          prev_angle;

  phasor_t     phasor_q[$];
  int          fail_count = 0;
  bit          recv_calm = 1'b0;
  int          recv_wait = 0;
  bit          prev_valid = 1'b0;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mul_q16(longint v, longint c);
    longint h;
    longint l;
    h = v >>> 24;
    l = v - h * 64'sd16777216;
    return h * c * 256 + ((l * c) >>> 16);
  endfunction

  function automatic void reset_phasor_model();
    cfg_points = POINTS_RESET;
    cfg_coef_a = 129460;
    cfg_coef_wy = 10252;
    cfg_two_over_n = 3277;
    cfg_base_freq = 49000;
    for (int k = 0; k < NUM_SUMS; k++) begin
      delay_one_q[k] = 0;
      delay_two_q[k] = 0;
      window_count[k] = k * POINTS_RESET / NUM_SUMS;
    end
    prev_angle = 0;
  endfunction

  function automatic void set_phasor_reg(int idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_POINTS:     cfg_points = v[8:0];
      REG_COEF_A:     cfg_coef_a = longint'($signed(v[17:0]));
      REG_COEF_WY:    cfg_coef_wy = v[16:0];
      REG_TWO_OVER_N: cfg_two_over_n = v[15:0];
      REG_BASE_FREQ:  cfg_base_freq = v[16:0];
      default: ;
    endcase
  endfunction

  function automatic bit step_phasor(logic signed [15:0] smp_v, output phasor_t p);
    longint x;
    longint s;
    longint re;
    longint im;
    longint re16;
    longint im16;
    longint cx;
    longint cy;
    longint nx;
    longint d;
    longint num;
    longint q;
    longint mag16;
    longint mag;
    bit [31:0] ang32;
    bit [31:0] rnd;
    int unsigned n;
    int sel;
    int ang;
    x = smp_v;
    n = cfg_points < 4 ? 4 : (cfg_points > MAX_POINTS ? MAX_POINTS : cfg_points);
    sel = -1;
    p = '0;
    for (int k = 0; k < NUM_SUMS; k++) begin
      s = mul_q16(delay_one_q[k], cfg_coef_a) - delay_two_q[k] + x * 65536;
      delay_two_q[k] = delay_one_q[k];
      delay_one_q[k] = clampl(s, -MAX48 - 1, MAX48);
      if (window_count[k] < MAX_POINTS) window_count[k]++;
      if (sel < 0 && window_count[k] >= n) sel = k;
    end
    if (sel < 0) return 1'b0;
    re = clampl((mul_q16(delay_one_q[sel], cfg_coef_a) >>> 1) - delay_two_q[sel],
                -MAX48 - 1, MAX48);
    im = clampl(mul_q16(delay_one_q[sel], cfg_coef_wy), -MAX48 - 1, MAX48);
    re16 = clampl((re * cfg_two_over_n) >>> 16, -CLAMP33, CLAMP33);
    im16 = clampl((im * cfg_two_over_n) >>> 16, -CLAMP33, CLAMP33);
    cx = re16;
    cy = im16;
    ang32 = 0;
    if (cx == 0 && cy == 0) begin
      mag16 = 0;
    end else begin
      if (cx < 0) begin
        cx = -cx;
        cy = -cy;
        ang32 = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        if (cy > 0) begin
          nx = cx + (cy >>> i);
          cy = cy - (cx >>> i);
          ang32 = ang32 + atan_angle(i[ITER_W-1:0]);
        end else begin
          nx = cx - (cy >>> i);
          cy = cy + (cx >>> i);
          ang32 = ang32 - atan_angle(i[ITER_W-1:0]);
        end
        cx = nx;
      end
      if (cx < 0) cx = 0;
      mag16 = (cx * CORDIC_GAIN24 + 64'sd8388608) >>> 24;
    end
    ang32 = ang32 + (32'(sel) << 30);
    rnd = ang32 + 32'h8000;
    ang = int'($signed(rnd[31:16]));
    d = ang - prev_angle;
    prev_angle = ang;
    num = d * 1000 + (NUM_SUMS * 65536) / 2;
    q = num >= 0 ? num / (NUM_SUMS * 65536)
                 : -((-num + NUM_SUMS * 65536 - 1) / (NUM_SUMS * 65536));
    mag = (mag16 + 32768) >>> 16;
    if (mag > 131071) mag = 131071;
    p.sum_index = sel[IDX_W-1:0];
    p.real_part = 17'(clampl((re16 + 32768) >>> 16, -65536, 65535));
    p.imag_part = 17'(clampl((im16 + 32768) >>> 16, -65536, 65535));
    p.magnitude = 17'(mag);
    p.phase_angle = 16'(ang);
    p.phase_step = 17'(d);
    p.frequency_mhz = 17'(clampl(cfg_base_freq + q, 0, 131071));
    delay_one_q[sel] = 0;
    delay_two_q[sel] = 0;
    window_count[sel] = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    phasor_t got;
    phasor_t want;
    if (res.valid && res.ready) begin
      got = '{res.sum_index, res.real_part, res.imag_part, res.magnitude,
              res.phase_angle, res.phase_step, res.frequency_mhz};
      if (phasor_q.size() == 0) begin
        report_mismatch("unexpected item, sum_index", got.sum_index, -1);
      end else begin
        want = phasor_q.pop_front();
        if (got.sum_index != want.sum_index)
          report_mismatch("sum_index", got.sum_index, want.sum_index);
        if (got.real_part != want.real_part)
          report_mismatch("real_part", got.real_part, want.real_part);
        if (got.imag_part != want.imag_part)
          report_mismatch("imag_part", got.imag_part, want.imag_part);
        if (got.magnitude != want.magnitude)
          report_mismatch("magnitude", got.magnitude, want.magnitude);
        if (got.phase_angle != want.phase_angle)
          report_mismatch("phase_angle", got.phase_angle, want.phase_angle);
        if (got.phase_step != want.phase_step)
          report_mismatch("phase_step", got.phase_step, want.phase_step);
        if (got.frequency_mhz != want.frequency_mhz)
          report_mismatch("frequency_mhz", got.frequency_mhz, want.frequency_mhz);
      end
      recv_wait = recv_calm ? 0 : $urandom_range(0, 14);
      res.ready <= (recv_wait == 0);
    end else if (res.valid && !prev_valid) begin
      res.ready <= (recv_wait == 0);
    end else if (recv_wait > 0) begin
      recv_wait--;
      res.ready <= (recv_wait == 0);
    end
    prev_valid <= res.valid && !(res.valid && res.ready);
  end

  task automatic send_sample(logic signed [15:0] s, bit calm, bit typed, phasor_t typed_p);
    int gap;
    phasor_t p;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp.valid <= 1'b1;
    smp.sample <= s;
    do @(posedge clk_i); while (!smp.ready);
    if (step_phasor(s, p)) phasor_q.push_back(typed ? typed_p : p);
  endtask

  task automatic write_phasor_regs(logic [CFG_DATA_W-1:0] v [5]);
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[CFG_IDX_W-1:0];
      cfg_data_i <= v[i];
      @(posedge clk_i);
      set_phasor_reg(i, v[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_results();
    smp.valid <= 1'b0;
    wait (phasor_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    #20000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    sample_row_t rows[$];
    sample_row_t r;
    logic [CFG_DATA_W-1:0] regs [5];
    phasor_t none;
    logic signed [15:0] s;
    real amp;
    real w;
    int kind;
    rst_ni <= 1'b0;
    smp.valid = 1'b0;
    smp.sample = '0;
    res.ready = 1'b1;
    none = '0;
    reset_phasor_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 10; i++) rows.push_back('{16'sd0, 1'b0, none});
    rows[9].typed = 1'b1;
    rows[9].phasor = '{2'd3, 17'sd0, 17'sd0, 17'd0, -16'sd16384, -17'sd16384, 17'd48938};
    for (int i = 0; i < 5; i++) rows.push_back('{16'sh7fff, 1'b0, none});
    for (int i = 0; i < 5; i++) rows.push_back('{-16'sh8000, 1'b0, none});
    rows.push_back('{16'sd1, 1'b0, none});
    rows.push_back('{-16'sd1, 1'b0, none});
    rows.push_back('{16'sh5555, 1'b0, none});
    rows.push_back('{-16'sh5556, 1'b0, none});
    foreach (rows[i]) send_sample(rows[i].sample, 1'b0, rows[i].typed, rows[i].phasor);
    drain_results();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: regs = '{18'd4, 18'd0, 18'd65536, 18'd32768, 18'd131071};
        1: regs = '{18'd256, 18'd131052, 18'd1608, 18'd512, 18'd0};
        2: regs = '{18'd0, 18'h20000, 18'd0, 18'd0, 18'd65535};
        3: regs = '{18'd511, 18'h1ffff, 18'd32768, 18'd16384, 18'd49000};
        4: regs = '{18'd40, 18'd129460, 18'd10252, 18'd3277, 18'd49000};
        default: begin
          regs[0] = $urandom_range(4, 64);
          regs[1] = $urandom;
          regs[2] = $urandom_range(0, 65536);
          regs[3] = $urandom_range(0, 32768);
          regs[4] = $urandom_range(0, 131071);
        end
      endcase
      write_phasor_regs(regs);
      recv_calm = (ph == 6);
      w = 6.2831853 / ((regs[0] < 4) ? 4.0 : real'(regs[0] > 256 ? 256 : regs[0]));
      amp = real'($urandom_range(100, 32767));
      for (int i = 0; i < 110; i++) begin
        kind = $urandom_range(0, 9);
        if (kind < 6)
          s = 16'($rtoi(amp * $cos(w * i + 0.3 * ph)));
        else if (kind < 8)
          s = 16'($urandom);
        else
          s = 16'($signed($urandom_range(0, 15)) - 8);
        send_sample(s, ph == 6, 1'b0, none);
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
